// ===== sv/cna_pkg.sv =====
// Shared definitions for the complex-number ALU: mode codes, default word format
// and the request and response payload structs.
// No dependencies.
`default_nettype none

package cna_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [3:0] MODE_ADD  = 4'd0;
    localparam logic [3:0] MODE_SUB  = 4'd1;
    localparam logic [3:0] MODE_MUL  = 4'd2;
    localparam logic [3:0] MODE_DIV  = 4'd3;
    localparam logic [3:0] MODE_CONJ = 4'd4;
    localparam logic [3:0] MODE_NEG  = 4'd5;
    localparam logic [3:0] MODE_MOD  = 4'd6;
    localparam logic [3:0] MODE_NORM = 4'd7;
    localparam logic [3:0] MODE_GT   = 4'd8;
    localparam logic [3:0] MODE_GE   = 4'd9;
    localparam logic [3:0] MODE_LT   = 4'd10;
    localparam logic [3:0] MODE_LE   = 4'd11;
    localparam logic [3:0] MODE_EQ   = 4'd12;
    localparam logic [3:0] MODE_NE   = 4'd13;

    typedef struct packed {
        logic [3:0]  mode;
        logic [31:0] a_real;
        logic [31:0] a_imag;
        logic [31:0] b_real;
        logic [31:0] b_imag;
    } req_t;

    typedef struct packed {
        logic [31:0] res_real;
        logic [31:0] res_imag;
        logic        compare_true;
        logic        div_by_zero;
        logic        saturated;
    } rsp_t;

endpackage

`default_nettype wire

// ===== sv/complex_number_alu.sv =====
// Stages in order: A, B, C, the square-root stages, D, E, the divider stages, output.
// Throughput: one request per cycle while the response is not stalled; the square-root and
// divider pipelines take one result bit per stage, which sets the depth.
// A stalled response freezes the whole pipeline, so nothing is lost or repeated.
// Reset (rst_n, asynchronous, active low) clears every stage's valid bit; payload
// registers are not reset.
`default_nettype none

// Complex-number ALU, top level. Depends on cna_pkg.
module complex_number_alu
    import cna_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    // Word format and derived widths.
    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;          // a product or a sum of two squares
    localparam int SW  = 2 * W + 1;      // a signed sum of two products
    localparam int QB  = W + 1;          // quotient bits kept by the divider
    localparam int RW  = 2 * W + QB;     // divider remainder
    localparam int CW  = 2 * W + F + QB; // width of the quotient range check
    localparam int RMW = W + 2;          // square-root remainder

    // Operand from a 32-bit field: the low W bits, sign taken from bit W-1.
    function automatic logic [W-1:0] take_op(input logic [31:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[W-1:0];
    endfunction

    // A W-bit result pattern placed on the 32-bit response field.
    function automatic logic [31:0] send_word(input logic [W-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[31:0];
    endfunction

    // Magnitude of a signed SW-bit value.
    function automatic logic [SW-1:0] mag_of(input logic [SW-1:0] v);
        return v[SW-1] ? (~v + SW'(1)) : v;
    endfunction

    // Shift a signed value right by F, rounding toward zero.
    function automatic logic [SW-1:0] trunc_shift(input logic [SW-1:0] v);
        logic [SW-1:0] m;
        m = mag_of(v) >> F;
        return v[SW-1] ? (~m + SW'(1)) : m;
    endfunction

    // Saturate a sign and magnitude to the word range; top bit flags clipping.
    function automatic logic [W:0] clip(input logic neg, input logic [SW-1:0] mag,
                                        input logic ovf);
        logic [SW-1:0] lim;
        logic [SW-1:0] m;
        logic          hit;
        lim = SW'(1) << (W - 1);
        if (neg)
        begin
            hit = ovf || (mag > lim);
            m   = hit ? lim : mag;
            m   = ~m + SW'(1);
        end
        else
        begin
            hit = ovf || (mag > (lim - SW'(1)));
            m   = hit ? (lim - SW'(1)) : mag;
        end
        return {hit, m[W-1:0]};
    endfunction

    // Stage payloads.
    typedef struct packed {
        logic [3:0]   mode;
        logic [W-1:0] ar;
        logic [W-1:0] ai;
        logic [W-1:0] br;
        logic [W-1:0] bi;
        logic         cmp;
        logic         dbz;
        logic         azero;
    } sa_t;

    typedef struct packed {
        logic [3:0]    mode;
        logic [PW-1:0] p0;
        logic [PW-1:0] p1;
        logic [PW-1:0] p2;
        logic [PW-1:0] p3;
        logic [PW-1:0] p4;
        logic [PW-1:0] p5;
        logic [W:0]    s_re;
        logic [W:0]    s_im;
        logic [W-1:0]  ar;
        logic [W-1:0]  ai;
        logic          cmp;
        logic          dbz;
        logic          azero;
    } sb_t;

    typedef struct packed {
        logic [3:0]     mode;
        logic           cmp;
        logic           dbz;
        logic           azero;
        logic [W-1:0]   ar;
        logic [W-1:0]   ai;
        logic [SW-1:0]  v_re;
        logic [SW-1:0]  v_im;
        logic           nr_neg;
        logic [PW-1:0]  nr_mag;
        logic           ni_neg;
        logic [PW-1:0]  ni_mag;
        logic [PW-1:0]  s;
        logic [PW-1:0]  rad;
        logic [RMW-1:0] rem;
        logic [W-1:0]   root;
    } sq_t;

    typedef struct packed {
        logic          cmp;
        logic          dbz;
        logic          use_div;
        logic [SW-1:0] v_re;
        logic [SW-1:0] v_im;
        logic          re_neg;
        logic          im_neg;
        logic [PW-1:0] re_mag;
        logic [PW-1:0] im_mag;
        logic [PW-1:0] den;
    } sd_t;

    typedef struct packed {
        logic          cmp;
        logic          dbz;
        logic          use_div;
        logic [SW-1:0] v_re;
        logic [SW-1:0] v_im;
        logic          re_neg;
        logic          im_neg;
        logic          re_ovf;
        logic          im_ovf;
        logic [RW-1:0] rem_re;
        logic [RW-1:0] rem_im;
        logic [QB-1:0] q_re;
        logic [QB-1:0] q_im;
        logic [PW-1:0] den;
    } dv_t;

    // Global advance: every stage moves unless the response register is held.
    logic en;
    logic rsp_valid_reg;
    rsp_t rsp_data_reg;
    rsp_t rsp_data_next;

    assign en        = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !en;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // ---------------------------------------------------------------------
    // Stage A: operand extraction, lexicographic compare and special cases.
    // The compare needs only the operands, so it is settled here and carried.
    // ---------------------------------------------------------------------
    sa_t  sa_reg, sa_next;
    logic va_reg;

    always_comb
    begin
        logic signed [W-1:0] ar, ai, br, bi;
        logic                gt, eq;
        ar = $signed(take_op(req_data.a_real));
        ai = $signed(take_op(req_data.a_imag));
        br = $signed(take_op(req_data.b_real));
        bi = $signed(take_op(req_data.b_imag));
        gt = (ar > br) || ((ar == br) && (ai > bi));
        eq = (ar == br) && (ai == bi);
        sa_next.mode  = req_data.mode;
        sa_next.ar    = ar;
        sa_next.ai    = ai;
        sa_next.br    = br;
        sa_next.bi    = bi;
        sa_next.dbz   = (req_data.mode == MODE_DIV) && (br == '0) && (bi == '0);
        sa_next.azero = (ar == '0) && (ai == '0);
        case (req_data.mode)
            MODE_GT: sa_next.cmp = gt;
            MODE_GE: sa_next.cmp = gt || eq;
            MODE_LT: sa_next.cmp = !gt && !eq;
            MODE_LE: sa_next.cmp = !gt;
            MODE_EQ: sa_next.cmp = eq;
            MODE_NE: sa_next.cmp = !eq;
            default: sa_next.cmp = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sa_reg <= sa_next;
    end

    // ---------------------------------------------------------------------
    // Stage B: six parallel signed multipliers. The two squares serve the
    // divisor magnitude in divide mode and the modulus of a otherwise.
    // Add, subtract, conjugate and negate are finished here.
    // ---------------------------------------------------------------------
    sb_t  sb_reg, sb_next;
    logic vb_reg;

    always_comb
    begin
        logic signed [W-1:0]  ar, ai, br, bi, x, y;
        logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
        logic signed [W:0]    s_re, s_im;
        ar = $signed(sa_reg.ar);
        ai = $signed(sa_reg.ai);
        br = $signed(sa_reg.br);
        bi = $signed(sa_reg.bi);
        x  = (sa_reg.mode == MODE_DIV) ? br : ar;
        y  = (sa_reg.mode == MODE_DIV) ? bi : ai;
        p0 = ar * br;
        p1 = ai * bi;
        p2 = ar * bi;
        p3 = ai * br;
        p4 = x * x;
        p5 = y * y;
        case (sa_reg.mode)
            MODE_ADD:
            begin
                s_re = ar + br;
                s_im = ai + bi;
            end
            MODE_SUB:
            begin
                s_re = ar - br;
                s_im = ai - bi;
            end
            MODE_CONJ:
            begin
                s_re = ar;
                s_im = -ai;
            end
            MODE_NEG:
            begin
                s_re = -ar;
                s_im = -ai;
            end
            default:
            begin
                s_re = '0;
                s_im = '0;
            end
        endcase
        sb_next.mode  = sa_reg.mode;
        sb_next.p0    = p0;
        sb_next.p1    = p1;
        sb_next.p2    = p2;
        sb_next.p3    = p3;
        sb_next.p4    = p4;
        sb_next.p5    = p5;
        sb_next.s_re  = s_re;
        sb_next.s_im  = s_im;
        sb_next.ar    = sa_reg.ar;
        sb_next.ai    = sa_reg.ai;
        sb_next.cmp   = sa_reg.cmp;
        sb_next.dbz   = sa_reg.dbz;
        sb_next.azero = sa_reg.azero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sb_reg <= sb_next;
    end

    // ---------------------------------------------------------------------
    // Stage C: combine products. Multiply is finished with a shift toward
    // zero; divide numerators go on as sign and magnitude; the sum of
    // squares seeds the square root and is kept as the divide divisor.
    // ---------------------------------------------------------------------
    sq_t  sq_reg [0:W];
    logic sqv_reg [0:W];
    sq_t  sc_next;

    always_comb
    begin
        logic signed [SW-1:0] mre, mim, nre, nim, vre, vim;
        logic signed [PW-1:0] p0, p1, p2, p3;
        logic signed [W:0]    s_re, s_im;
        logic [SW-1:0]        nr_abs, ni_abs;
        p0   = $signed(sb_reg.p0);
        p1   = $signed(sb_reg.p1);
        p2   = $signed(sb_reg.p2);
        p3   = $signed(sb_reg.p3);
        s_re = $signed(sb_reg.s_re);
        s_im = $signed(sb_reg.s_im);
        mre  = p0 - p1;
        mim  = p2 + p3;
        nre  = p0 + p1;
        nim  = p3 - p2;
        case (sb_reg.mode)
            MODE_ADD, MODE_SUB, MODE_CONJ, MODE_NEG:
            begin
                vre = s_re;
                vim = s_im;
            end
            MODE_MUL:
            begin
                vre = $signed(trunc_shift(mre));
                vim = $signed(trunc_shift(mim));
            end
            default:
            begin
                vre = '0;
                vim = '0;
            end
        endcase
        nr_abs          = mag_of(nre);
        ni_abs          = mag_of(nim);
        sc_next.mode    = sb_reg.mode;
        sc_next.cmp     = sb_reg.cmp;
        sc_next.dbz     = sb_reg.dbz;
        sc_next.azero   = sb_reg.azero;
        sc_next.ar      = sb_reg.ar;
        sc_next.ai      = sb_reg.ai;
        sc_next.v_re    = vre;
        sc_next.v_im    = vim;
        sc_next.nr_neg  = nre[SW-1];
        sc_next.nr_mag  = nr_abs[PW-1:0];
        sc_next.ni_neg  = nim[SW-1];
        sc_next.ni_mag  = ni_abs[PW-1:0];
        sc_next.s       = sb_reg.p4 + sb_reg.p5;
        sc_next.rad     = sb_reg.p4 + sb_reg.p5;
        sc_next.rem     = '0;
        sc_next.root    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqv_reg[0] <= 1'b0;
        else if (en)
            sqv_reg[0] <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sq_reg[0] <= sc_next;
    end

    // ---------------------------------------------------------------------
    // Square root: one root bit per stage, two radicand bits consumed each
    // time, restoring digit recurrence.
    // ---------------------------------------------------------------------
    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        sq_t              stage_next;
        logic [RMW+1:0]   rem_sh;
        logic [RMW+1:0]   trial;

        always_comb
        begin
            stage_next     = sq_reg[k];
            rem_sh         = {sq_reg[k].rem, sq_reg[k].rad[PW-1 -: 2]};
            trial          = (RMW + 2)'({sq_reg[k].root, 2'b01});
            stage_next.rad = sq_reg[k].rad << 2;
            if (rem_sh >= trial)
            begin
                stage_next.rem  = RMW'(rem_sh - trial);
                stage_next.root = {sq_reg[k].root[W-2:0], 1'b1};
            end
            else
            begin
                stage_next.rem  = rem_sh[RMW-1:0];
                stage_next.root = {sq_reg[k].root[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sqv_reg[k+1] <= 1'b0;
            else if (en)
                sqv_reg[k+1] <= sqv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[k+1] <= stage_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage D: choose what the divider works on. Normalize divides each part
    // of a by the modulus; divide uses the numerators and |b|^2. Modulus is
    // finished here. Zero a in normalize stays zero without the divider.
    // ---------------------------------------------------------------------
    sd_t  sd_reg, sd_next;
    logic vd_reg;

    always_comb
    begin
        logic signed [W:0] ae, ie;
        logic [W:0]        a_abs, i_abs;
        ae = $signed(sq_reg[W].ar);
        ie = $signed(sq_reg[W].ai);
        a_abs = ae[W] ? (~ae + (W + 1)'(1)) : ae;
        i_abs = ie[W] ? (~ie + (W + 1)'(1)) : ie;
        sd_next.cmp     = sq_reg[W].cmp;
        sd_next.dbz     = sq_reg[W].dbz;
        sd_next.use_div = ((sq_reg[W].mode == MODE_DIV) && !sq_reg[W].dbz)
                       || ((sq_reg[W].mode == MODE_NORM) && !sq_reg[W].azero);
        sd_next.v_re    = sq_reg[W].v_re;
        sd_next.v_im    = sq_reg[W].v_im;
        sd_next.re_neg  = sq_reg[W].nr_neg;
        sd_next.im_neg  = sq_reg[W].ni_neg;
        sd_next.re_mag  = sq_reg[W].nr_mag;
        sd_next.im_mag  = sq_reg[W].ni_mag;
        sd_next.den     = sq_reg[W].s;
        case (sq_reg[W].mode)
            MODE_MOD:
            begin
                sd_next.v_re = SW'(sq_reg[W].root);
            end
            MODE_NORM:
            begin
                sd_next.re_neg = ae[W];
                sd_next.im_neg = ie[W];
                sd_next.re_mag = PW'(a_abs);
                sd_next.im_mag = PW'(i_abs);
                sd_next.den    = PW'(sq_reg[W].root);
            end
            default:
            begin
                sd_next.den = sq_reg[W].s;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (en)
            vd_reg <= sqv_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sd_reg <= sd_next;
    end

    // ---------------------------------------------------------------------
    // Stage E: range check. A quotient of 2^QB or more can only saturate, so
    // it is flagged here and the divider needs just QB quotient bits.
    // ---------------------------------------------------------------------
    dv_t  dv_reg [0:QB];
    logic dvv_reg [0:QB];
    dv_t  se_next;

    always_comb
    begin
        logic [CW-1:0] xr, xi, lim;
        xr  = CW'(sd_reg.re_mag) << F;
        xi  = CW'(sd_reg.im_mag) << F;
        lim = CW'(sd_reg.den) << QB;
        se_next.cmp     = sd_reg.cmp;
        se_next.dbz     = sd_reg.dbz;
        se_next.use_div = sd_reg.use_div;
        se_next.v_re    = sd_reg.v_re;
        se_next.v_im    = sd_reg.v_im;
        se_next.re_neg  = sd_reg.re_neg;
        se_next.im_neg  = sd_reg.im_neg;
        se_next.re_ovf  = xr >= lim;
        se_next.im_ovf  = xi >= lim;
        se_next.rem_re  = xr[RW-1:0];
        se_next.rem_im  = xi[RW-1:0];
        se_next.q_re    = '0;
        se_next.q_im    = '0;
        se_next.den     = sd_reg.den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dvv_reg[0] <= 1'b0;
        else if (en)
            dvv_reg[0] <= vd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_reg[0] <= se_next;
    end

    // ---------------------------------------------------------------------
    // Divider: two restoring dividers sharing one divisor, one quotient bit
    // per stage, most significant bit first.
    // ---------------------------------------------------------------------
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int SH = QB - 1 - j;
        dv_t           stage_next;
        logic [RW-1:0] trial;

        always_comb
        begin
            stage_next = dv_reg[j];
            trial      = RW'(dv_reg[j].den) << SH;
            if (dv_reg[j].rem_re >= trial)
            begin
                stage_next.rem_re = dv_reg[j].rem_re - trial;
                stage_next.q_re   = {dv_reg[j].q_re[QB-2:0], 1'b1};
            end
            else
            begin
                stage_next.q_re   = {dv_reg[j].q_re[QB-2:0], 1'b0};
            end
            if (dv_reg[j].rem_im >= trial)
            begin
                stage_next.rem_im = dv_reg[j].rem_im - trial;
                stage_next.q_im   = {dv_reg[j].q_im[QB-2:0], 1'b1};
            end
            else
            begin
                stage_next.q_im   = {dv_reg[j].q_im[QB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dvv_reg[j+1] <= 1'b0;
            else if (en)
                dvv_reg[j+1] <= dvv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[j+1] <= stage_next;
        end
    end

    // ---------------------------------------------------------------------
    // Output stage: saturate both parts and register the response. Compare,
    // divide-by-zero and unused modes arrive with zero values, so they
    // come out as zero with no clipping.
    // ---------------------------------------------------------------------
    always_comb
    begin
        logic [W:0] cr, ci;
        if (dv_reg[QB].use_div)
        begin
            cr = clip(dv_reg[QB].re_neg, SW'(dv_reg[QB].q_re), dv_reg[QB].re_ovf);
            ci = clip(dv_reg[QB].im_neg, SW'(dv_reg[QB].q_im), dv_reg[QB].im_ovf);
        end
        else
        begin
            cr = clip(dv_reg[QB].v_re[SW-1], mag_of(dv_reg[QB].v_re), 1'b0);
            ci = clip(dv_reg[QB].v_im[SW-1], mag_of(dv_reg[QB].v_im), 1'b0);
        end
        rsp_data_next.res_real     = send_word(cr[W-1:0]);
        rsp_data_next.res_imag     = send_word(ci[W-1:0]);
        rsp_data_next.compare_true = dv_reg[QB].cmp;
        rsp_data_next.div_by_zero  = dv_reg[QB].dbz;
        rsp_data_next.saturated    = cr[W] | ci[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (en)
            rsp_valid_reg <= dvv_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rsp_data_reg <= rsp_data_next;
    end

endmodule

`default_nettype wire

// ===== sv/cna_checker.sv =====
// Port-level assertions for the complex-number ALU and the bind that attaches them.
// Depends on cna_pkg and complex_number_alu.
`default_nettype none

module cna_checker
    import cna_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_stall,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp_data
);

    // A held response keeps its valid and payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // The pipeline refuses a request exactly when the response is held.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("request stall does not follow response stall");

    // Division by zero gives zero parts with no clipping and no compare flag.
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.div_by_zero |->
            rsp_data.res_real == 32'd0 && rsp_data.res_imag == 32'd0
            && !rsp_data.saturated && !rsp_data.compare_true)
        else $error("divide by zero response not clean");

    // A true compare carries zero parts and no clipping.
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.compare_true |->
            rsp_data.res_real == 32'd0 && rsp_data.res_imag == 32'd0
            && !rsp_data.saturated)
        else $error("compare response carries data");

endmodule

bind complex_number_alu cna_checker u_cna_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for complex_number_alu: random and directed requests are checked
// against a behavioural predictor of the fixed-point arithmetic.
// Depends on cna_pkg and complex_number_alu.
`default_nettype none

module tb;
    import cna_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic signed [127:0] WORD_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] WORD_MIN = -128'sh8000_0000;

    // Expected-response store and predictor.  Every accepted request yields
    // exactly one response, so a plain FIFO of predictions is enough.
    class alu_scoreboard;
        rsp_t expected_q[$];
        int   mismatches;
        int   checked;

        // Clip to the 32-bit word and note any clipping.
        function automatic logic [31:0] clip(input logic signed [127:0] v, inout bit sat);
            if (v > WORD_MAX)
            begin
                sat = 1;
                return WORD_MAX[31:0];
            end
            if (v < WORD_MIN)
            begin
                sat = 1;
                return WORD_MIN[31:0];
            end
            return v[31:0];
        endfunction

        // Arithmetic shift right of the magnitude, i.e. truncation toward zero.
        function automatic logic signed [127:0] drop_frac(input logic signed [127:0] v);
            if (v < 0)
                return -((-v) >>> FRAC);
            return v >>> FRAC;
        endfunction

        // Integer square root, rounded down.
        function automatic logic signed [127:0] root(input logic signed [127:0] v);
            logic signed [127:0] r;
            logic signed [127:0] c;
            r = 0;
            for (int b = 33; b >= 0; b--)
            begin
                c = r | (128'sd1 <<< b);
                if (c * c <= v)
                    r = c;
            end
            return r;
        endfunction

        function automatic int lex_order(input rsp_t dummy, input req_t q);
            logic signed [31:0] ar, ai, br, bi;
            ar = q.a_real; ai = q.a_imag; br = q.b_real; bi = q.b_imag;
            if (ar != br)
                return (ar > br) ? 1 : -1;
            if (ai != bi)
                return (ai > bi) ? 1 : -1;
            return 0;
        endfunction

        function automatic rsp_t predict(input req_t q);
            rsp_t                r;
            logic signed [127:0] ar, ai, br, bi, pr, pi, sq, m;
            bit                  sat;
            int                  c;
            ar = $signed(q.a_real);
            ai = $signed(q.a_imag);
            br = $signed(q.b_real);
            bi = $signed(q.b_imag);
            pr = 0;
            pi = 0;
            sat = 0;
            r = '0;
            case (q.mode)
                MODE_ADD:
                begin
                    pr = ar + br; pi = ai + bi;
                end
                MODE_SUB:
                begin
                    pr = ar - br; pi = ai - bi;
                end
                MODE_MUL:
                begin
                    pr = drop_frac(ar * br - ai * bi);
                    pi = drop_frac(ar * bi + ai * br);
                end
                MODE_DIV:
                begin
                    sq = br * br + bi * bi;
                    if (sq == 0)
                        r.div_by_zero = 1;
                    else
                    begin
                        // Signed division in SystemVerilog truncates toward zero.
                        pr = ((ar * br + ai * bi) <<< FRAC) / sq;
                        pi = ((ai * br - ar * bi) <<< FRAC) / sq;
                    end
                end
                MODE_CONJ:
                begin
                    pr = ar; pi = -ai;
                end
                MODE_NEG:
                begin
                    pr = -ar; pi = -ai;
                end
                MODE_MOD, MODE_NORM:
                begin
                    m = root(ar * ar + ai * ai);
                    if (q.mode == MODE_MOD)
                        pr = m;
                    else if (m == 0)
                    begin
                        pr = ar; pi = ai;
                    end
                    else
                    begin
                        pr = (ar <<< FRAC) / m;
                        pi = (ai <<< FRAC) / m;
                    end
                end
                MODE_GT, MODE_GE, MODE_LT, MODE_LE, MODE_EQ, MODE_NE:
                begin
                    c = lex_order(r, q);
                    case (q.mode)
                        MODE_GT: r.compare_true = (c > 0);
                        MODE_GE: r.compare_true = (c >= 0);
                        MODE_LT: r.compare_true = (c < 0);
                        MODE_LE: r.compare_true = (c <= 0);
                        MODE_EQ: r.compare_true = (c == 0);
                        default: r.compare_true = (c != 0);
                    endcase
                end
                default:
                begin
                end
            endcase
            r.res_real  = clip(pr, sat);
            r.res_imag  = clip(pi, sat);
            r.saturated = sat;
            return r;
        endfunction

        function void note_request(input req_t q);
            expected_q.push_back(predict(q));
        endfunction

        function void check_response(input rsp_t got);
            rsp_t exp;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response %h", got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.res_real !== exp.res_real || got.res_imag !== exp.res_imag ||
                got.compare_true !== exp.compare_true ||
                got.div_by_zero !== exp.div_by_zero || got.saturated !== exp.saturated)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response %0d real %h/%h imag %h/%h cmp %b/%b dbz %b/%b sat %b/%b",
                             checked, got.res_real, exp.res_real, got.res_imag, exp.res_imag,
                             got.compare_true, exp.compare_true, got.div_by_zero,
                             exp.div_by_zero, got.saturated, exp.saturated);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    alu_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  recv_hold;
    int  sent;

    complex_number_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // The monitor samples both channels at the rising edge, before the block's
    // registers update, so every accepted request and response is seen once.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            sb.note_request(req_data);
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp_data);
    end

    // The response side stalls at random, or for a long stretch when a hold
    // count has been loaded; the count runs down in this process alone.
    initial
    begin
        rsp_stall = 1;
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                recv_hold--;
                rsp_stall <= 1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one request and hold it until accepted.  Valid is only written
    // once per falling edge, so back-to-back requests keep it high.
    task automatic send_request(input req_t q);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 0;
            @(negedge clk);
        end
        req_valid <= 1;
        req_data  <= q;
        do
            @(posedge clk);
        while (req_stall);
        sent++;
    endtask

    // Operand values lean towards the extremes and small numbers, where the
    // saturation and rounding corners live.
    function automatic logic [31:0] pick_word();
        logic [31:0] v;
        case ($urandom_range(7))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0;
            3, 4:
            begin
                v = $urandom_range(32'h3_FFFF);
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic req_t random_request();
        req_t q;
        q.mode   = 4'($urandom_range(15));
        q.a_real = pick_word();
        q.a_imag = pick_word();
        q.b_real = pick_word();
        q.b_imag = pick_word();
        // Compares are more telling when the parts coincide.
        if ($urandom_range(3) == 0)
            q.b_real = q.a_real;
        if ($urandom_range(3) == 0)
            q.b_imag = q.a_imag;
        // Give division by zero and the zero operand a fair share.
        if ($urandom_range(9) == 0)
        begin
            q.b_real = 0;
            q.b_imag = 0;
        end
        if ($urandom_range(11) == 0)
        begin
            q.a_real = 0;
            q.a_imag = 0;
        end
        return q;
    endfunction

    function automatic req_t make_req(input logic [3:0] m, input logic [31:0] ar,
                                      input logic [31:0] ai, input logic [31:0] br,
                                      input logic [31:0] bi);
        req_t q;
        q.mode = m; q.a_real = ar; q.a_imag = ai; q.b_real = br; q.b_imag = bi;
        return q;
    endfunction

    task automatic drain();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        sent = 0;
        recv_hold = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 0;
        req_valid = 0;
        req_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed part: every mode once with plain values, the two unused modes
        // among them, then the corners: saturating sums and products, divide by
        // zero, normalising zero, negating and conjugating the most negative value,
        // and equal compares.
        for (int m = 0; m < 16; m++)
            send_request(make_req(4'(m), 32'h0003_8000, 32'hFFFE_0000,
                                  32'h0001_4000, 32'h0000_C000));
        send_request(make_req(MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_request(make_req(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_req(MODE_DIV, 32'h7FFF_FFFF, 32'h1, 32'h0, 32'h0));
        send_request(make_req(MODE_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1));
        send_request(make_req(MODE_NORM, 32'h0, 32'h0, 32'h0, 32'h0));
        send_request(make_req(MODE_NEG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
        send_request(make_req(MODE_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
        send_request(make_req(MODE_MOD, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
        send_request(make_req(MODE_EQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_req(MODE_LE, 32'h1, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF));

        // Random phases with different idling on each side.
        send_idle_pct = 14; recv_idle_pct = 76;
        for (int i = 0; i < 170; i++)
            send_request(random_request());

        // Long receiver hold while the sender offers a request every cycle:
        // the pipeline fills and the block must push back on its input.
        recv_hold = 300;
        send_idle_pct = 0;
        for (int i = 0; i < 100; i++)
            send_request(random_request());

        send_idle_pct = 76; recv_idle_pct = 14;
        for (int i = 0; i < 170; i++)
            send_request(random_request());

        // Sender pauses until every outstanding response has come back.
        @(negedge clk);
        req_valid <= 0;
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < 70; i++)
            send_request(random_request());
        @(negedge clk);
        req_valid <= 0;

        drain();
        repeat (100) @(posedge clk);
        $display("Sent %0d requests over all modes, with idling and back-pressure on both sides.",
                 sent);
        $display("Checked %0d responses, %0d mismatches, %0d left over.",
                 sb.checked, sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("Timeout waiting for the block.");
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/cna_pkg.sv
sv/complex_number_alu.sv
sv/cna_checker.sv
dv/tb.sv
